### design/blar_pkg.sv
// shared types, codes and defaults for the bounded list block
`timescale 1ns / 1ps
package blar_pkg;

    // default sizing
    localparam int CAPACITY_DEF = 16;
    localparam int ID_WIDTH_DEF = 16;

    // result status codes
    localparam logic [1:0] ST_APPENDED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_REMOVED   = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // saturation limit of the success counters
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // request beat
    typedef struct packed {
        logic        operation;
        logic [15:0] item_id;
    } req_t;

    // result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  occupancy;
        logic [15:0] append_total;
        logic [15:0] remove_total;
    } rsp_t;

endpackage

### design/bounded_list_append_remove.sv
// Bounded ordered list of identifiers with append and remove-by-value.
// A request beat (req) is taken when start is high and busy is low.
// Each request gives exactly one result beat on rsp, marked by done for
// one cycle; the receiver must take it then, there is no stall.
// Append: result in the cycle after the request; busy never rises, so a new
// request may follow in the next cycle.
// Remove: one shared read port and one comparator walk the valid entries,
// one entry a cycle; once the match is found each later entry is written
// back one place lower in the same pass. Result comes once the pass over
// the valid entries is over; an empty list gives it in the cycle after the
// request with busy low. Otherwise busy is high meanwhile.
// The pass over the entry memory bounds the rate: no new request is taken
// until a remove's pass is over.
// Reset clears occupancy and both counters; entry storage is not cleared,
// only entries below the occupancy are ever compared.
`timescale 1ns / 1ps
module bounded_list_append_remove
#(
    parameter int CAPACITY = blar_pkg::CAPACITY_DEF,
    parameter int ID_WIDTH = blar_pkg::ID_WIDTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  blar_pkg::req_t  req,
    output logic            done,
    output blar_pkg::rsp_t  rsp
);
    import blar_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                state_reg,   state_next;
    logic [ID_WIDTH-1:0] id_reg,      id_next;
    logic [CNT_W-1:0]    rd_idx_reg,  rd_idx_next;
    logic [CNT_W-1:0]    rd_pos_reg,  rd_pos_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                found_reg,   found_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [15:0]         app_reg,     app_next;
    logic [15:0]         rem_reg,     rem_next;
    logic                done_reg,    done_next;
    rsp_t                rsp_reg,     rsp_next;

    // entry memory
    logic [ID_WIDTH-1:0] mem [CAPACITY];
    logic [ID_WIDTH-1:0] rd_data_reg;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ID_WIDTH-1:0] wr_data;
    logic [IDX_W-1:0]    rd_addr;

    // identifier trimmed or widened to the stored width
    logic [ID_WIDTH+15:0] id_wide;
    logic [ID_WIDTH-1:0]  id_in;
    assign id_wide = {{ID_WIDTH{1'b0}}, req.item_id};
    assign id_in   = id_wide[ID_WIDTH-1:0];

    // helpers for the result beat
    logic [CNT_W+4:0] occ_wide;
    logic             match;
    logic             last_pos;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] count_inc;

    assign count_m1  = count_reg - CNT_W'(1);
    assign count_inc = count_reg + CNT_W'(1);
    assign pos_m1    = rd_pos_reg - CNT_W'(1);
    assign match     = (rd_data_reg == id_reg);
    assign last_pos  = (rd_pos_reg == count_m1);

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer and datapath
    always_comb
    begin
        state_next   = state_reg;
        id_next      = id_reg;
        rd_idx_next  = rd_idx_reg;
        rd_pos_next  = rd_pos_reg;
        rd_pend_next = 1'b0;
        found_next   = found_reg;
        count_next   = count_reg;
        app_next     = app_reg;
        rem_next     = rem_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_data      = id_in;
        rd_addr      = rd_idx_reg[IDX_W-1:0];
        occ_wide     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next = id_in;
                    if (req.operation == OP_APPEND)
                    begin
                        // append at the end or reject when full
                        if (count_reg < CAP_CNT)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_inc;
                            if (app_reg != COUNT_MAX)
                            begin
                                app_next = app_reg + 16'd1;
                            end
                            rsp_next.status = ST_APPENDED;
                        end
                        else
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        occ_wide               = {5'd0, count_next};
                        rsp_next.occupancy     = occ_wide[4:0];
                        rsp_next.append_total  = app_next;
                        rsp_next.remove_total  = rem_reg;
                        done_next              = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing to search
                        occ_wide               = {5'd0, count_reg};
                        rsp_next.status        = ST_NOT_FOUND;
                        rsp_next.occupancy     = occ_wide[4:0];
                        rsp_next.append_total  = app_reg;
                        rsp_next.remove_total  = rem_reg;
                        done_next              = 1'b1;
                    end
                    else
                    begin
                        state_next  = S_SCAN;
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read while entries remain
                if (rd_idx_reg < count_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_pos_next  = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                // compare returned entry or shift it down past the match
                if (rd_pend_reg)
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pos_m1[IDX_W-1:0];
                        wr_data = rd_data_reg;
                    end
                    else if (match)
                    begin
                        found_next = 1'b1;
                    end
                    if (last_pos)
                    begin
                        state_next   = S_IDLE;
                        rd_pend_next = 1'b0;
                        if (found_reg || match)
                        begin
                            count_next = count_m1;
                            if (rem_reg != COUNT_MAX)
                            begin
                                rem_next = rem_reg + 16'd1;
                            end
                            rsp_next.status = ST_REMOVED;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                        occ_wide              = {5'd0, count_next};
                        rsp_next.occupancy    = occ_wide[4:0];
                        rsp_next.append_total = app_reg;
                        rsp_next.remove_total = rem_next;
                        done_next             = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
            count_reg   <= '0;
            app_reg     <= '0;
            rem_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
            count_reg   <= count_next;
            app_reg     <= app_next;
            rem_reg     <= rem_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        rd_idx_reg <= rd_idx_next;
        rd_pos_reg <= rd_pos_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg == S_SCAN);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### dv/tb_bounded_list_append_remove.sv
// self-checking testbench for the bounded list append/remove block
`timescale 1ns / 1ps
module tb_bounded_list_append_remove;
    import blar_pkg::*;

    // tracks list contents and counters, queues the expected result beats
    class list_tracker;
        logic [15:0] slots [CAPACITY_DEF];
        int unsigned fill;
        logic [15:0] appends;
        logic [15:0] removes;
        rsp_t        pending [$];
        int unsigned mismatches;

        function new();
            fill       = 0;
            appends    = '0;
            removes    = '0;
            mismatches = 0;
        endfunction

        // apply one accepted request beat and queue its result
        function void take_request(req_t r);
            rsp_t want;
            int   hit;
            hit = -1;
            if (r.operation == OP_APPEND)
            begin
                if (fill < CAPACITY_DEF)
                begin
                    slots[fill] = r.item_id;
                    fill++;
                    if (appends != COUNT_MAX)
                        appends++;
                    want.status = ST_APPENDED;
                end
                else
                    want.status = ST_FULL;
            end
            else
            begin
                // first match among the valid entries only
                for (int i = 0; i < fill; i++)
                    if (hit < 0 && slots[i] == r.item_id)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int k = hit; k + 1 < fill; k++)
                        slots[k] = slots[k + 1];
                    fill--;
                    if (removes != COUNT_MAX)
                        removes++;
                    want.status = ST_REMOVED;
                end
                else
                    want.status = ST_NOT_FOUND;
            end
            want.occupancy    = 5'(fill);
            want.append_total = appends;
            want.remove_total = removes;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // compare one result beat with the oldest pending one
        function void match_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 50)
                    $error("result beat with nothing pending: status %0d", got.status);
                return;
            end
            want = pending.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("append_total", want.append_total, got.append_total);
            compare_field("remove_total", want.remove_total, got.remove_total);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    list_tracker tracker = new();

    bounded_list_append_remove i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watch both sides of the block at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.match_result(rsp);
            if (start && !busy)
                tracker.take_request(req);
        end
    end

    function automatic req_t make_req(logic op, logic [15:0] id);
        req_t r;
        r.operation = op;
        r.item_id   = id;
        return r;
    endfunction

    // idle with start low for the length that gap gives, then hold the beat until
    // taken; called and returns at a falling edge
    task automatic send_request(req_t r, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // stop sending until every pending result beat has come back
    task automatic drain_results();
        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // watchdog
    initial
    begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          mode;
        int          append_pct;
        bit          tight;
        logic        op;
        logic [15:0] id;
        int          gap;

        mode       = 0;
        append_pct = 50;
        tight      = 1'b0;
        start      = 1'b0;
        req        = '0;
        rst_n      = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, extremes, duplicates, full list
        send_request(make_req(OP_REMOVE, 16'h1234), $urandom_range(0, 6));
        send_request(make_req(OP_APPEND, 16'h0000), $urandom_range(0, 6));
        send_request(make_req(OP_APPEND, 16'hFFFF), $urandom_range(0, 6));
        send_request(make_req(OP_APPEND, 16'h0000), $urandom_range(0, 6));
        send_request(make_req(OP_APPEND, 16'h0005), $urandom_range(0, 6));
        for (int k = 1; k <= 12; k++)
            send_request(make_req(OP_APPEND, 16'h8000 + 16'(k)), 0);
        send_request(make_req(OP_APPEND, 16'h0007), $urandom_range(0, 6));
        send_request(make_req(OP_REMOVE, 16'h0000), $urandom_range(0, 6));
        send_request(make_req(OP_REMOVE, 16'hFFFF), $urandom_range(0, 6));
        send_request(make_req(OP_REMOVE, 16'h800C), $urandom_range(0, 6));
        send_request(make_req(OP_REMOVE, 16'h0000), $urandom_range(0, 6));
        send_request(make_req(OP_REMOVE, 16'hABCD), $urandom_range(0, 6));
        drain_results();

        // random: bursts that fill, empty or churn the list
        for (int n = 0; n < 1800; n++)
        begin
            if (n % 40 == 0)
            begin
                mode  = $urandom_range(0, 2);
                tight = ($urandom_range(0, 3) == 0);
            end
            if (n % 300 == 150)
                drain_results();
            append_pct = (mode == 0) ? 80 : ((mode == 1) ? 20 : 50);
            op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_REMOVE;
            if (op == OP_REMOVE && tracker.fill > 0 && $urandom_range(0, 9) < 7)
                id = tracker.slots[$urandom_range(0, tracker.fill - 1)];
            else if ($urandom_range(0, 9) < 4)
                id = 16'($urandom_range(0, 7));
            else if ($urandom_range(0, 9) == 0)
                id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                id = 16'($urandom);
            gap = tight ? 0 : $urandom_range(0, 6);
            send_request(make_req(op, id), gap);
        end

        // empty the list, then a short mixed tail on small identifiers
        drain_results();
        while (tracker.fill != 0)
            send_request(make_req(OP_REMOVE, tracker.slots[0]), 0);
        for (int n = 0; n < 40; n++)
            send_request(make_req($urandom_range(0, 1) ? OP_APPEND : OP_REMOVE,
                                  16'($urandom_range(0, 3))), $urandom_range(0, 6));

        // wind down and let any stray beat show up
        drain_results();
        repeat (CAPACITY_DEF + 4) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
